FILE: src/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg - shared types and constants for the graph degree statistics core
// Sizes of the degree stores, request and result records, back-end states.
// ----------------------------------------------------------------------------
package gds_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int DEGREE_BITS  = 16;
    localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int VTX_W        = 7;
    localparam int OUT_DEG_W    = 16;
    localparam int SINK_W       = (DEGREE_BITS > VTX_W) ? DEGREE_BITS : VTX_W;

    localparam int IN_TDATA_W   = 16;
    localparam int OUT_FIELDS_W = 77;
    localparam int OUT_TDATA_W  = 80;

    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic [VTX_W-1:0]       VC_RESET = VTX_W'(64);
    localparam logic [VTX_W-1:0]       VTX_MAX  = VTX_W'(MAX_VERTICES);
    localparam logic [DEGREE_BITS-1:0] DEG_MAX  = {DEGREE_BITS{1'b1}};

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_REPORT   = 1'b1;

    typedef enum logic [1:0] {
        REQ_EDGE_OK  = 2'd0,
        REQ_EDGE_REJ = 2'd1,
        REQ_REPORT   = 2'd2
    } t_req_kind;

    typedef struct packed {
        t_req_kind         kind;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic              loop_edge;
    } t_req;

    typedef struct packed {
        logic                 accepted;
        logic [VTX_W-1:0]     vertex;
        logic [OUT_DEG_W-1:0] out_degree;
        logic [OUT_DEG_W-1:0] in_degree;
        logic [OUT_DEG_W-1:0] max_out_degree;
        logic [OUT_DEG_W-1:0] max_in_degree;
        logic                 is_max_out;
        logic                 is_max_in;
        logic                 has_self_loop;
        logic                 is_universal_sink;
        logic                 graph_has_sink;
        logic                 last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_EDGE_WR = 3'b010,
        ST_REP_OUT = 3'b100
    } t_state;

endpackage

FILE: src/graph_degree_statistics_core.sv
// ----------------------------------------------------------------------------
// graph_degree_statistics_core - directed graph in/out degree counter
// Counts vertex degrees over a stream of edges and reports them per vertex.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tuser: command; tdata: source_vertex, dest_vertex
//  m_axis    out        tdata: result fields; tlast: last
//  cfg       in         i_cfg_wdata: vertex_count, written when i_cfg_we
//
//  An edge passes through the back end as a degree RAM read, then a write.
//  A report walks the clamped vertex count: one RAM read per
//  vertex, pipelined against the output register, then the stores clear at
//  once via valid bits.
//  A two-entry request queue lets intake run ahead of the back end.
//  Reset is synchronous, active low; a stalled m_axis holds the back end.
// ----------------------------------------------------------------------------
module graph_degree_statistics_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gds_pkg::VTX_W-1:0]         i_cfg_wdata,   // vertex_count
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [6:0] source_vertex, [13:7] dest_vertex, [15:14] zero
    input  logic [gds_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tuser,  // command
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] accepted, [7:1] vertex, [23:8] out_degree, [39:24] in_degree,
    // [55:40] max_out_degree, [71:56] max_in_degree, [72] is_max_out,
    // [73] is_max_in, [74] has_self_loop, [75] is_universal_sink,
    // [76] graph_has_sink, [79:77] zero
    output logic [gds_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast
);

    logic [gds_pkg::VTX_W-1:0] r_vertex_count;
    logic [gds_pkg::VTX_W-1:0] w_n;
    logic                      w_req_valid;
    gds_pkg::t_req             w_req;
    logic                      w_req_pop;
    gds_pkg::t_result          w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= gds_pkg::VC_RESET;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_wdata;
        end
    end

    // clamp the vertex count to the store depth
    assign w_n = (r_vertex_count > gds_pkg::VTX_MAX) ? gds_pkg::VTX_MAX : r_vertex_count;

    gds_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_n         (w_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_command   (s_axis_tuser),
        .i_src       (s_axis_tdata[6:0]),
        .i_dst       (s_axis_tdata[13:7]),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_pop   (w_req_pop)
    );

    gds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_n         (w_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_req_pop   (w_req_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (w_res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {
        (gds_pkg::OUT_TDATA_W - gds_pkg::OUT_FIELDS_W)'(0),
        w_res.graph_has_sink,
        w_res.is_universal_sink,
        w_res.has_self_loop,
        w_res.is_max_in,
        w_res.is_max_out,
        w_res.max_in_degree,
        w_res.max_out_degree,
        w_res.in_degree,
        w_res.out_degree,
        w_res.vertex,
        w_res.accepted
    };
    assign m_axis_tlast = w_res.last;

endmodule

FILE: src/gds_ram.sv
// ----------------------------------------------------------------------------
// gds_ram - generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module gds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/gds_front.sv
// ----------------------------------------------------------------------------
// gds_front - request intake and classification
// Range-checks edges against the vertex count and queues classified requests.
// ----------------------------------------------------------------------------
module gds_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [gds_pkg::VTX_W-1:0]  i_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_command,
    input  logic [gds_pkg::VTX_W-1:0]  i_src,
    input  logic [gds_pkg::VTX_W-1:0]  i_dst,
    output logic                       o_req_valid,
    output gds_pkg::t_req              o_req,
    input  logic                       i_req_pop
);

    gds_pkg::t_req                       r_queue [gds_pkg::Q_DEPTH];
    logic [gds_pkg::Q_PTR_W-1:0]         r_wr_ptr;
    logic [gds_pkg::Q_PTR_W-1:0]         r_rd_ptr;
    logic [gds_pkg::Q_CNT_W-1:0]         r_count;
    gds_pkg::t_req                       w_req;
    logic                                w_in_range;
    logic                                w_push;
    logic                                w_pop;

    always_comb begin
        w_in_range = (i_src != '0) && (i_dst != '0) && (i_src <= i_n) && (i_dst <= i_n);
        w_req.src_addr  = gds_pkg::ADDR_W'(i_src - gds_pkg::VTX_W'(1));
        w_req.dst_addr  = gds_pkg::ADDR_W'(i_dst - gds_pkg::VTX_W'(1));
        w_req.loop_edge = (i_src == i_dst);
        if (i_command == gds_pkg::CMD_REPORT) begin
            w_req.kind = gds_pkg::REQ_REPORT;
        end else if (w_in_range) begin
            w_req.kind = gds_pkg::REQ_EDGE_OK;
        end else begin
            w_req.kind = gds_pkg::REQ_EDGE_REJ;
        end
    end

    assign o_ready     = (r_count != gds_pkg::Q_CNT_W'(gds_pkg::Q_DEPTH));
    assign o_req_valid = (r_count != '0);
    assign o_req       = r_queue[r_rd_ptr];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = i_req_pop && o_req_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == gds_pkg::Q_PTR_W'(gds_pkg::Q_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == gds_pkg::Q_PTR_W'(gds_pkg::Q_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: src/gds_back.sv
// ----------------------------------------------------------------------------
// gds_back - degree store update and report walk
// Read-modify-write of the degree RAMs per edge, vertex walk per report,
// running maxima and flags, and the output result register.
// ----------------------------------------------------------------------------
module gds_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [gds_pkg::VTX_W-1:0]  i_n,
    input  logic                       i_req_valid,
    input  gds_pkg::t_req              i_req,
    output logic                       o_req_pop,
    output logic                       o_res_valid,
    output gds_pkg::t_result           o_res,
    input  logic                       i_res_ready
);

    localparam int AW = gds_pkg::ADDR_W;
    localparam int DW = gds_pkg::DEGREE_BITS;
    localparam int NV = gds_pkg::MAX_VERTICES;

    gds_pkg::t_state        r_state, n_state;
    gds_pkg::t_req          r_req, n_req;
    logic [AW-1:0]          r_k, n_k;
    logic [NV-1:0]          r_vld_o, n_vld_o;
    logic [NV-1:0]          r_vld_i, n_vld_i;
    logic                   r_rd_vld_o, n_rd_vld_o;
    logic                   r_rd_vld_i, n_rd_vld_i;
    logic [DW-1:0]          r_max_out, n_max_out;
    logic [DW-1:0]          r_max_in, n_max_in;
    logic                   r_self, n_self;
    logic                   r_any_sink, n_any_sink;
    logic                   r_o_valid, n_o_valid;
    gds_pkg::t_result       r_o_res, n_o_res;

    logic                   w_re;
    logic [AW-1:0]          w_raddr_o, w_raddr_i;
    logic                   w_we;
    logic [DW-1:0]          w_rd_o, w_rd_i;
    logic [DW-1:0]          w_od, w_id, w_od_inc, w_id_inc;
    logic [DW-1:0]          w_max_out_e, w_max_in_e;
    logic                   w_edge_ok;
    logic                   w_slot_free;
    logic [gds_pkg::VTX_W-1:0] w_vertex;
    logic                   w_rep_last;
    logic                   w_sink;

    gds_ram #(.WIDTH(DW), .DEPTH(NV)) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_req.src_addr),
        .i_wdata (w_od_inc),
        .i_re    (w_re),
        .i_raddr (w_raddr_o),
        .o_rdata (w_rd_o)
    );

    gds_ram #(.WIDTH(DW), .DEPTH(NV)) u_in_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_req.dst_addr),
        .i_wdata (w_id_inc),
        .i_re    (w_re),
        .i_raddr (w_raddr_i),
        .o_rdata (w_rd_i)
    );

    // an entry never written since the last clear reads as zero
    assign w_od        = r_rd_vld_o ? w_rd_o : '0;
    assign w_id        = r_rd_vld_i ? w_rd_i : '0;
    assign w_od_inc    = (w_od == gds_pkg::DEG_MAX) ? w_od : w_od + 1'b1;
    assign w_id_inc    = (w_id == gds_pkg::DEG_MAX) ? w_id : w_id + 1'b1;
    assign w_edge_ok   = (r_req.kind == gds_pkg::REQ_EDGE_OK);
    assign w_max_out_e = (w_edge_ok && (w_od_inc > r_max_out)) ? w_od_inc : r_max_out;
    assign w_max_in_e  = (w_edge_ok && (w_id_inc > r_max_in)) ? w_id_inc : r_max_in;
    assign w_slot_free = !r_o_valid || i_res_ready;
    assign w_vertex    = gds_pkg::VTX_W'(r_k) + gds_pkg::VTX_W'(1);
    assign w_rep_last  = (w_vertex == i_n);
    assign w_sink      = (w_od == '0) &&
                         (gds_pkg::SINK_W'(w_id) ==
                          gds_pkg::SINK_W'(i_n - gds_pkg::VTX_W'(1)));

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_k        = r_k;
        n_vld_o    = r_vld_o;
        n_vld_i    = r_vld_i;
        n_rd_vld_o = r_rd_vld_o;
        n_rd_vld_i = r_rd_vld_i;
        n_max_out  = r_max_out;
        n_max_in   = r_max_in;
        n_self     = r_self;
        n_any_sink = r_any_sink;
        n_o_valid  = r_o_valid && !i_res_ready;
        n_o_res    = r_o_res;
        o_req_pop  = 1'b0;
        w_re       = 1'b0;
        w_we       = 1'b0;
        w_raddr_o  = '0;
        w_raddr_i  = '0;

        case (r_state)
            gds_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop = 1'b1;
                    n_req     = i_req;
                    case (i_req.kind)
                        gds_pkg::REQ_REPORT: begin
                            if (i_n == '0) begin
                                // nothing to walk: just clear
                                n_vld_o   = '0;
                                n_vld_i   = '0;
                                n_max_out = '0;
                                n_max_in  = '0;
                                n_self    = 1'b0;
                            end else begin
                                w_re       = 1'b1;
                                n_k        = '0;
                                n_any_sink = 1'b0;
                                n_state    = gds_pkg::ST_REP_OUT;
                            end
                        end
                        default: begin
                            w_re      = 1'b1;
                            w_raddr_o = i_req.src_addr;
                            w_raddr_i = i_req.dst_addr;
                            n_state   = gds_pkg::ST_EDGE_WR;
                        end
                    endcase
                end
            end
            gds_pkg::ST_EDGE_WR: begin
                if (w_slot_free) begin
                    n_o_valid                = 1'b1;
                    n_o_res                  = '0;
                    n_o_res.accepted         = w_edge_ok;
                    n_o_res.max_out_degree   = gds_pkg::OUT_DEG_W'(w_max_out_e);
                    n_o_res.max_in_degree    = gds_pkg::OUT_DEG_W'(w_max_in_e);
                    n_o_res.has_self_loop    = r_self || (w_edge_ok && r_req.loop_edge);
                    n_o_res.last             = 1'b1;
                    if (w_edge_ok) begin
                        w_we                    = 1'b1;
                        n_vld_o[r_req.src_addr] = 1'b1;
                        n_vld_i[r_req.dst_addr] = 1'b1;
                        n_max_out               = w_max_out_e;
                        n_max_in                = w_max_in_e;
                        n_self                  = r_self || r_req.loop_edge;
                    end
                    n_state = gds_pkg::ST_IDLE;
                end
            end
            gds_pkg::ST_REP_OUT: begin
                if (w_slot_free) begin
                    n_o_valid                  = 1'b1;
                    n_o_res.accepted           = 1'b1;
                    n_o_res.vertex             = w_vertex;
                    n_o_res.out_degree         = gds_pkg::OUT_DEG_W'(w_od);
                    n_o_res.in_degree          = gds_pkg::OUT_DEG_W'(w_id);
                    n_o_res.max_out_degree     = gds_pkg::OUT_DEG_W'(r_max_out);
                    n_o_res.max_in_degree      = gds_pkg::OUT_DEG_W'(r_max_in);
                    n_o_res.is_max_out         = (w_od == r_max_out);
                    n_o_res.is_max_in          = (w_id == r_max_in);
                    n_o_res.has_self_loop      = r_self;
                    n_o_res.is_universal_sink  = w_sink;
                    n_o_res.graph_has_sink     = r_any_sink || w_sink;
                    n_o_res.last               = w_rep_last;
                    n_any_sink                 = r_any_sink || w_sink;
                    if (w_rep_last) begin
                        n_vld_o   = '0;
                        n_vld_i   = '0;
                        n_max_out = '0;
                        n_max_in  = '0;
                        n_self    = 1'b0;
                        n_state   = gds_pkg::ST_IDLE;
                    end else begin
                        // fetch the next vertex while this one leaves
                        n_k       = r_k + 1'b1;
                        w_re      = 1'b1;
                        w_raddr_o = r_k + 1'b1;
                        w_raddr_i = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = gds_pkg::ST_IDLE;
            end
        endcase

        if (w_re) begin
            n_rd_vld_o = r_vld_o[w_raddr_o];
            n_rd_vld_i = r_vld_i[w_raddr_i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gds_pkg::ST_IDLE;
            r_vld_o    <= '0;
            r_vld_i    <= '0;
            r_max_out  <= '0;
            r_max_in   <= '0;
            r_self     <= 1'b0;
            r_any_sink <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_vld_o    <= n_vld_o;
            r_vld_i    <= n_vld_i;
            r_max_out  <= n_max_out;
            r_max_in   <= n_max_in;
            r_self     <= n_self;
            r_any_sink <= n_any_sink;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_k        <= n_k;
        r_rd_vld_o <= n_rd_vld_o;
        r_rd_vld_i <= n_rd_vld_i;
        r_o_res    <= n_o_res;
    end

    assign o_res_valid = r_o_valid;
    assign o_res       = r_o_res;

endmodule
